// ===== rtl/cuau_pkg.sv =====
`default_nettype none

package cuau_pkg;

    // Field widths
    localparam int SAMPLE_W = 24;
    localparam int SOS_W    = 16;
    localparam int FRAC_W   = 16;

    localparam logic [SOS_W-1:0] SOS_RESET = 16'd13107;

    // Datapath widths, from the worst-case magnitudes of each term
    localparam int PV_W     = 41;   // -velocity * step_over_spacing
    localparam int NA_W     = 27;   // cubic numerator
    localparam int NC_W     = 28;   // linear numerator and 3*nb
    localparam int P1_W     = NA_W + SAMPLE_W;
    localparam int G1_W     = P1_W - FRAC_W;
    localparam int G1_SPLIT = 17;
    localparam int PP1_W    = G1_W - G1_SPLIT + SAMPLE_W;
    localparam int SUM1_W   = G1_W + SAMPLE_W;
    localparam int G2_W     = SUM1_W - FRAC_W;
    localparam int G2_SPLIT = 22;
    localparam int PP2H_W   = G2_W - G2_SPLIT + SAMPLE_W;
    localparam int PP2L_W   = G2_SPLIT + 1 + SAMPLE_W;
    localparam int SUM2_W   = G2_W + SAMPLE_W;
    localparam int S_W      = SUM2_W - FRAC_W + 1;

    // Divide by six: bias, range window and reciprocal of three
    localparam int T_W     = 26;
    localparam int QP_W    = 2 * T_W;
    localparam int Q_SHIFT = T_W + 1;

    localparam int ROUND_HALF = 1 << (FRAC_W - 1);
    localparam int DIV_BIAS   = 3;

    localparam logic signed [S_W-1:0] DIV_BOUND = S_W'(6 * (1 << (SAMPLE_W - 1)));
    localparam logic [T_W-1:0] RECIP3 = T_W'(((1 << Q_SHIFT) + 1) / 3);

    // Stencil coefficients
    localparam logic signed [NC_W-1:0] K2 = NC_W'(2);
    localparam logic signed [NC_W-1:0] K3 = NC_W'(3);
    localparam logic signed [NC_W-1:0] K6 = NC_W'(6);

    localparam logic signed [SAMPLE_W-1:0] SAT_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic signed [SAMPLE_W-1:0] SAT_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

    localparam int H_STAGES = 8;
    localparam int D_STAGES = 3;

    typedef logic signed [SAMPLE_W-1:0] sample_t;

    typedef struct packed {
        logic advance;
        logic valid;
    } cuau_flow_t;

endpackage

`default_nettype wire

// ===== rtl/cuau_if.sv =====
`default_nettype none

interface cuau_stencil_if
    import cuau_pkg::*;
();
    logic    valid;
    logic    ready;
    sample_t sample_minus_two;
    sample_t sample_minus_one;
    sample_t sample_center;
    sample_t sample_plus_one;
    sample_t sample_plus_two;
    sample_t velocity;

    modport source (
        output valid, sample_minus_two, sample_minus_one, sample_center,
               sample_plus_one, sample_plus_two, velocity,
        input  ready
    );
    modport sink (
        input  valid, sample_minus_two, sample_minus_one, sample_center,
               sample_plus_one, sample_plus_two, velocity,
        output ready
    );
endinterface

interface cuau_result_if
    import cuau_pkg::*;
();
    logic    valid;
    logic    ready;
    sample_t new_sample;
    logic    saturated;

    modport source (output valid, new_sample, saturated, input ready);
    modport sink   (input valid, new_sample, saturated, output ready);
endinterface

interface cuau_cfg_if
    import cuau_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [SOS_W-1:0] step_over_spacing;

    modport source (output valid, step_over_spacing, input ready);
    modport sink   (input valid, step_over_spacing, output ready);
endinterface

`default_nettype wire

// ===== rtl/cubic_upwind_advection_update_unit.sv =====
`default_nettype none

// Cubic upwind advection update for one cell along one axis (x or y sweep).
// stencil: one beat carries the five-sample window f(-2)..f(+2) and the local
//   velocity, all signed Q8.16. result: one beat per stencil beat, with the
//   advected value (signed Q8.16, clipped to 24 bits) and a saturated flag.
// cfg: write channel for step_over_spacing (dt/spacing, unsigned Q0.16); always
//   ready, written at the beat. Write it only while no beat is in flight.
// Depth: eleven register stages from stencil to result.
// Throughput: one beat per cycle while result is not stalled. The depth is set
//   by the Horner chain: three dependent multiplies by xi, the wider two cut
//   into two partial products each, followed by a reciprocal multiply for the
//   rounded divide by six.
// Reset: all stage valid bits clear, step_over_spacing returns to 13107.
// Stall: while result holds a beat that is not taken, every stage freezes and
//   stencil.ready drops; nothing is lost or repeated, bubbles are not squeezed.
module cubic_upwind_advection_update_unit
    import cuau_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    cuau_stencil_if.sink   stencil,
    cuau_result_if.source  result,
    cuau_cfg_if.sink       cfg
);

    logic [SOS_W-1:0]      sos_reg;
    logic                  advance;
    cuau_flow_t            horner_flow;
    cuau_flow_t            div_flow;
    logic                  sum_valid;
    logic signed [S_W-1:0] scaled_sum;
    logic                  out_valid;

    // Config register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sos_reg <= SOS_RESET;
        end
        else if (cfg.valid)
        begin
            sos_reg <= cfg.step_over_spacing;
        end
    end

    assign cfg.ready = 1'b1;

    // Whole pipe moves unless the output register holds an untaken beat
    assign advance       = !out_valid || result.ready;
    assign stencil.ready = advance;

    assign horner_flow.advance = advance;
    assign horner_flow.valid   = stencil.valid;
    assign div_flow.advance    = advance;
    assign div_flow.valid      = sum_valid;

    cuau_horner u_horner (
        .clk               (clk),
        .rst_n             (rst_n),
        .flow              (horner_flow),
        .step_over_spacing (sos_reg),
        .sample_minus_two  (stencil.sample_minus_two),
        .sample_minus_one  (stencil.sample_minus_one),
        .sample_center     (stencil.sample_center),
        .sample_plus_one   (stencil.sample_plus_one),
        .sample_plus_two   (stencil.sample_plus_two),
        .velocity          (stencil.velocity),
        .sum_valid         (sum_valid),
        .scaled_sum        (scaled_sum)
    );

    cuau_div6_sat u_div6_sat (
        .clk        (clk),
        .rst_n      (rst_n),
        .flow       (div_flow),
        .scaled_sum (scaled_sum),
        .out_valid  (out_valid),
        .new_sample (result.new_sample),
        .saturated  (result.saturated)
    );

    assign result.valid = out_valid;

`ifndef SYNTHESIS
    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.ready |-> !stencil.ready)
        else $error("stencil accepted while result is stalled");

    a_sat_at_bound: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.saturated |->
            (result.new_sample == SAT_MAX) || (result.new_sample == SAT_MIN))
        else $error("saturated beat not at a range bound");

    a_cfg_written: assert property (@(posedge clk) disable iff (!rst_n)
        cfg.valid |=> sos_reg == $past(cfg.step_over_spacing))
        else $error("step_over_spacing write lost");
`endif

endmodule

`default_nettype wire

// ===== rtl/cuau_horner.sv =====
`default_nettype none

// Shift, stencil numerators and Horner evaluation: eight stages, output is 6x the update.
module cuau_horner
    import cuau_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  cuau_flow_t             flow,
    input  logic [SOS_W-1:0]       step_over_spacing,
    input  sample_t                sample_minus_two,
    input  sample_t                sample_minus_one,
    input  sample_t                sample_center,
    input  sample_t                sample_plus_one,
    input  sample_t                sample_plus_two,
    input  sample_t                velocity,
    output logic                   sum_valid,
    output logic signed [S_W-1:0]  scaled_sum
);

    logic [H_STAGES-1:0] vld_reg;

    // stage 1
    logic signed [SAMPLE_W:0]  vel_neg;
    logic signed [SOS_W:0]     sos_s;
    logic signed [PV_W-1:0]    pv_next;
    logic signed [NC_W-1:0]    fm2_x, fm1_x, f0_x, f1_x, f2_x;
    logic signed [NC_W-1:0]    na_up, na_dn, nc_up, nc_dn, nb3;
    logic                      vel_pos;
    logic signed [NA_W-1:0]    na_next;
    logic signed [NC_W-1:0]    nc_next;
    logic signed [PV_W-1:0]    pv_reg;
    logic signed [NA_W-1:0]    na1_reg, na2_reg;
    logic signed [NC_W-1:0]    nb3_1_reg, nb3_2_reg, nb3_3_reg;
    logic signed [NC_W-1:0]    nc1_reg, nc2_reg, nc3_reg, nc4_reg, nc5_reg;
    sample_t                   f0_1_reg, f0_2_reg, f0_3_reg, f0_4_reg;
    sample_t                   f0_5_reg, f0_6_reg, f0_7_reg;

    // stage 2
    logic signed [PV_W-1:0]    pv_rnd;
    sample_t                   xi_next;
    sample_t                   xi2_reg, xi3_reg, xi4_reg, xi5_reg, xi6_reg;

    // stage 3..8
    logic signed [P1_W-1:0]    p1_next, p1_reg, p1_rnd;
    logic signed [G1_W-1:0]    g1_next, g1_reg;
    logic signed [G1_W-G1_SPLIT-1:0] g1_hi;
    logic signed [G1_SPLIT:0]  g1_lo;
    logic signed [PP1_W-1:0]   pp1h_next, pp1l_next, pp1h_reg, pp1l_reg;
    logic signed [SUM1_W-1:0]  sum1;
    logic signed [G2_W-1:0]    g2_next, g2_reg;
    logic signed [G2_W-G2_SPLIT-1:0] g2_hi;
    logic signed [G2_SPLIT:0]  g2_lo;
    logic signed [PP2H_W-1:0]  pp2h_next, pp2h_reg;
    logic signed [PP2L_W-1:0]  pp2l_next, pp2l_reg;
    logic signed [SUM2_W-1:0]  sum2;
    logic signed [S_W-1:0]     s_next, s_reg;

    assign vel_neg = -(($bits(vel_neg))'(velocity));
    assign sos_s   = $signed({1'b0, step_over_spacing});
    assign pv_next = PV_W'(vel_neg) * PV_W'(sos_s);

    assign fm2_x = NC_W'(sample_minus_two);
    assign fm1_x = NC_W'(sample_minus_one);
    assign f0_x  = NC_W'(sample_center);
    assign f1_x  = NC_W'(sample_plus_one);
    assign f2_x  = NC_W'(sample_plus_two);

    // upwind through f(-2)..f(+1), downwind through f(-1)..f(+2); zero takes downwind
    assign vel_pos = !velocity[SAMPLE_W-1] && (velocity != '0);
    assign na_up   = f1_x - K3 * f0_x + K3 * fm1_x - fm2_x;
    assign nc_up   = K2 * f1_x + K3 * f0_x - K6 * fm1_x + fm2_x;
    assign na_dn   = f2_x - K3 * f1_x + K3 * f0_x - fm1_x;
    assign nc_dn   = K6 * f1_x - f2_x - K3 * f0_x - K2 * fm1_x;
    assign nb3     = K3 * (f1_x - K2 * f0_x + fm1_x);
    assign na_next = NA_W'(vel_pos ? na_up : na_dn);
    assign nc_next = vel_pos ? nc_up : nc_dn;

    assign pv_rnd  = pv_reg + PV_W'(ROUND_HALF);
    assign xi_next = $signed(pv_rnd[FRAC_W+SAMPLE_W-1:FRAC_W]);

    assign p1_next = P1_W'(na2_reg) * P1_W'(xi2_reg);

    assign p1_rnd  = p1_reg + P1_W'(ROUND_HALF);
    assign g1_next = $signed(p1_rnd[P1_W-1:FRAC_W]) + G1_W'(nb3_3_reg);

    // g1 * xi as two partial products
    assign g1_hi     = $signed(g1_reg[G1_W-1:G1_SPLIT]);
    assign g1_lo     = $signed({1'b0, g1_reg[G1_SPLIT-1:0]});
    assign pp1h_next = PP1_W'(g1_hi) * PP1_W'(xi4_reg);
    assign pp1l_next = PP1_W'(g1_lo) * PP1_W'(xi4_reg);

    assign sum1    = (SUM1_W'(pp1h_reg) <<< G1_SPLIT) + SUM1_W'(pp1l_reg)
                   + SUM1_W'(ROUND_HALF);
    assign g2_next = $signed(sum1[SUM1_W-1:FRAC_W]) + G2_W'(nc5_reg);

    assign g2_hi     = $signed(g2_reg[G2_W-1:G2_SPLIT]);
    assign g2_lo     = $signed({1'b0, g2_reg[G2_SPLIT-1:0]});
    assign pp2h_next = PP2H_W'(g2_hi) * PP2H_W'(xi6_reg);
    assign pp2l_next = PP2L_W'(g2_lo) * PP2L_W'(xi6_reg);

    assign sum2   = (SUM2_W'(pp2h_reg) <<< G2_SPLIT) + SUM2_W'(pp2l_reg)
                  + SUM2_W'(ROUND_HALF);
    assign s_next = S_W'($signed(sum2[SUM2_W-1:FRAC_W])) + S_W'(K6) * S_W'(f0_7_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (flow.advance)
        begin
            vld_reg <= {vld_reg[H_STAGES-2:0], flow.valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (flow.advance)
        begin
            pv_reg    <= pv_next;
            na1_reg   <= na_next;
            nb3_1_reg <= nb3;
            nc1_reg   <= nc_next;
            f0_1_reg  <= sample_center;

            xi2_reg   <= xi_next;
            na2_reg   <= na1_reg;
            nb3_2_reg <= nb3_1_reg;
            nc2_reg   <= nc1_reg;
            f0_2_reg  <= f0_1_reg;

            p1_reg    <= p1_next;
            xi3_reg   <= xi2_reg;
            nb3_3_reg <= nb3_2_reg;
            nc3_reg   <= nc2_reg;
            f0_3_reg  <= f0_2_reg;

            g1_reg    <= g1_next;
            xi4_reg   <= xi3_reg;
            nc4_reg   <= nc3_reg;
            f0_4_reg  <= f0_3_reg;

            pp1h_reg  <= pp1h_next;
            pp1l_reg  <= pp1l_next;
            xi5_reg   <= xi4_reg;
            nc5_reg   <= nc4_reg;
            f0_5_reg  <= f0_4_reg;

            g2_reg    <= g2_next;
            xi6_reg   <= xi5_reg;
            f0_6_reg  <= f0_5_reg;

            pp2h_reg  <= pp2h_next;
            pp2l_reg  <= pp2l_next;
            f0_7_reg  <= f0_6_reg;

            s_reg     <= s_next;
        end
    end

    assign sum_valid  = vld_reg[H_STAGES-1];
    assign scaled_sum = s_reg;

endmodule

`default_nettype wire

// ===== rtl/cuau_div6_sat.sv =====
`default_nettype none

// Rounded divide by six and clip to 24 bits: range check, reciprocal multiply, output.
module cuau_div6_sat
    import cuau_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cuau_flow_t            flow,
    input  logic signed [S_W-1:0] scaled_sum,
    output logic                  out_valid,
    output sample_t               new_sample,
    output logic                  saturated
);

    logic [D_STAGES-1:0]   vld_reg;
    logic signed [S_W-1:0] n_biased;
    logic signed [S_W-1:0] m_offset;
    logic                  hi_next, lo_next;
    logic [T_W-1:0]        t_reg;
    logic                  hi1_reg, lo1_reg, hi2_reg, lo2_reg;
    logic [QP_W-1:0]       qp_next, qp_reg;
    logic [SAMPLE_W-1:0]   q;
    sample_t               new_sample_next;
    sample_t               new_sample_reg;
    logic                  saturated_reg;

    // floor((s+3)/6); inside the window the offset value is below 12*2^23
    assign n_biased = scaled_sum + S_W'(DIV_BIAS);
    assign hi_next  = n_biased >= DIV_BOUND;
    assign lo_next  = n_biased < -DIV_BOUND;
    assign m_offset = n_biased + DIV_BOUND;

    assign qp_next = QP_W'(t_reg) * QP_W'(RECIP3);

    // subtracting 2^23 from the offset quotient flips its top bit
    assign q = qp_reg[Q_SHIFT+SAMPLE_W-1:Q_SHIFT];

    always_comb
    begin
        if (hi2_reg)
        begin
            new_sample_next = SAT_MAX;
        end
        else if (lo2_reg)
        begin
            new_sample_next = SAT_MIN;
        end
        else
        begin
            new_sample_next = $signed({~q[SAMPLE_W-1], q[SAMPLE_W-2:0]});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (flow.advance)
        begin
            vld_reg <= {vld_reg[D_STAGES-2:0], flow.valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (flow.advance)
        begin
            t_reg          <= m_offset[T_W:1];
            hi1_reg        <= hi_next;
            lo1_reg        <= lo_next;
            qp_reg         <= qp_next;
            hi2_reg        <= hi1_reg;
            lo2_reg        <= lo1_reg;
            new_sample_reg <= new_sample_next;
            saturated_reg  <= hi2_reg || lo2_reg;
        end
    end

    assign out_valid  = vld_reg[D_STAGES-1];
    assign new_sample = new_sample_reg;
    assign saturated  = saturated_reg;

endmodule

`default_nettype wire
